/* sv/qts_pkg.sv */
// Shared types and helpers for the quoted token splitter.
// Holds the result kinds, the per-item result bundle and the whitespace test.
// Depends on nothing.
package qts_pkg;

    localparam int CHAR_W  = 16;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_LPAREN    = 16'h0028;
    localparam logic [CHAR_W-1:0] CH_RPAREN    = 16'h0029;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOT  = 1'b1;

    typedef enum logic [2:0] {
        KIND_CHAR  = 3'd0,
        KIND_END   = 3'd1,
        KIND_PAREN = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic              quoted;
    } t_res;

    // All results one item causes, in order; cnt is how many are live.
    typedef struct packed {
        logic [CNT_W-1:0]    cnt;
        t_res [MAX_RES-1:0]  res;
    } t_bundle;

    // Queue status seen by the back end.
    typedef struct packed {
        logic    empty;
        t_bundle head;
    } t_q_stat;

    function automatic t_res mk_res(t_kind kind, logic [CHAR_W-1:0] ch, logic quoted);
        t_res r;
        r.kind   = kind;
        r.ch     = ch;
        r.quoted = quoted;
        return r;
    endfunction

    function automatic logic is_space16(logic [CHAR_W-1:0] c);
        logic s;
        s = 1'b0;
        if (c >= 16'h0009 && c <= 16'h000D) s = 1'b1;
        if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) s = 1'b1;
        if (c >= 16'h2000 && c <= 16'h200A) s = 1'b1;
        if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) s = 1'b1;
        if (c == 16'h205F || c == 16'h3000) s = 1'b1;
        return s;
    endfunction

endpackage

/* sv/qts_front.sv */
// Front end: accepts characters, tracks quote/escape/token flags and
// builds the bundle of results each item causes. Uses qts_pkg.
module qts_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_action,
    input  logic [qts_pkg::CHAR_W-1:0] i_char_code,
    output logic                  o_push,
    output qts_pkg::t_bundle      o_bundle
);
    import qts_pkg::*;

    logic r_in_quotes, r_esc, r_tok_open, r_bwq, r_tok_q;
    logic n_in_quotes, n_esc, n_tok_open, n_bwq, n_tok_q;
    t_bundle b;

    always_comb begin
        logic [CNT_W-1:0] k;
        k           = '0;
        b.res       = '0;
        n_in_quotes = r_in_quotes;
        n_esc       = r_esc;
        n_tok_open  = r_tok_open;
        n_bwq       = r_bwq;
        n_tok_q     = r_tok_q;

        if (i_action == ACT_EOT) begin
            if (r_esc) begin
                b.res[k] = mk_res(KIND_CHAR, CH_BACKSLASH, 1'b0);
                k = k + 1'b1;
                n_tok_open = 1'b1;
            end
            if (r_in_quotes) begin
                b.res[k] = mk_res(KIND_ERROR, '0, 1'b0);
                k = k + 1'b1;
            end else begin
                if (n_tok_open) begin
                    b.res[k] = mk_res(KIND_END, '0, r_tok_q);
                    k = k + 1'b1;
                end
                b.res[k] = mk_res(KIND_DONE, '0, 1'b0);
                k = k + 1'b1;
            end
            // return to the reset state for the next text
            n_in_quotes = 1'b0;
            n_esc       = 1'b0;
            n_tok_open  = 1'b0;
            n_bwq       = 1'b0;
            n_tok_q     = 1'b0;
        end else if (r_esc) begin
            b.res[k] = mk_res(KIND_CHAR, i_char_code, 1'b0);
            k = k + 1'b1;
            n_tok_open = 1'b1;
            n_esc      = 1'b0;
        end else if (i_char_code == CH_BACKSLASH) begin
            n_esc = 1'b1;
        end else if (i_char_code == CH_QUOTE) begin
            if (!r_tok_open && !r_in_quotes) begin
                n_bwq = 1'b1;
            end else if (!r_bwq) begin
                b.res[k] = mk_res(KIND_CHAR, i_char_code, 1'b0);
                k = k + 1'b1;
                n_tok_open = 1'b1;
            end
            n_in_quotes = !r_in_quotes;
            n_tok_q     = n_bwq;
        end else if (!r_in_quotes && is_space16(i_char_code)) begin
            if (r_tok_open) begin
                b.res[k] = mk_res(KIND_END, '0, r_tok_q);
                k = k + 1'b1;
                n_tok_open = 1'b0;
                n_tok_q    = 1'b0;
                n_bwq      = 1'b0;
            end
        end else if (!r_in_quotes &&
                     (i_char_code == CH_LPAREN || i_char_code == CH_RPAREN)) begin
            if (r_tok_open) begin
                b.res[k] = mk_res(KIND_END, '0, r_tok_q);
                k = k + 1'b1;
                n_tok_open = 1'b0;
                n_tok_q    = 1'b0;
                n_bwq      = 1'b0;
            end
            b.res[k] = mk_res(KIND_PAREN, i_char_code, 1'b0);
            k = k + 1'b1;
        end else begin
            b.res[k] = mk_res(KIND_CHAR, i_char_code, 1'b0);
            k = k + 1'b1;
            n_tok_open = 1'b1;
        end
        b.cnt = k;
    end

    assign o_bundle = b;
    assign o_push   = i_accept && (b.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes <= 1'b0;
            r_esc       <= 1'b0;
            r_tok_open  <= 1'b0;
            r_bwq       <= 1'b0;
            r_tok_q     <= 1'b0;
        end else if (i_accept) begin
            r_in_quotes <= n_in_quotes;
            r_esc       <= n_esc;
            r_tok_open  <= n_tok_open;
            r_bwq       <= n_bwq;
            r_tok_q     <= n_tok_q;
        end
    end

endmodule

/* sv/qts_queue.sv */
// Short bundle queue between front and back end.
// Uses qts_pkg for the bundle type and depth.
module qts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qts_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output qts_pkg::t_q_stat o_stat
);
    import qts_pkg::*;

    t_bundle            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= n_count;
        end
    end

endmodule

/* sv/qts_back.sv */
// Back end: takes bundles from the queue and sends their results out one
// per ready cycle, flagging the last of each item. Uses qts_pkg.
module qts_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qts_pkg::t_q_stat      i_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_kind,
    output logic [qts_pkg::CHAR_W-1:0] o_char_code_res,
    output logic                  o_quoted,
    output logic                  o_last
);
    import qts_pkg::*;

    logic             r_busy;
    t_bundle          r_bun;
    logic [CNT_W-1:0] r_idx;
    logic             last_res, done, load;
    t_res             cur;

    assign cur      = r_bun.res[r_idx];
    assign last_res = (r_idx == r_bun.cnt - 1'b1);
    assign done     = r_busy && i_ready && last_res;
    assign load     = (!r_busy || done) && !i_stat.empty;
    assign o_pop    = load;

    assign o_valid         = r_busy;
    assign o_kind          = cur.kind;
    assign o_char_code_res = cur.ch;
    assign o_quoted        = cur.quoted;
    assign o_last          = last_res;

    always_ff @(posedge i_clk) begin
        if (load) r_bun <= i_stat.head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

/* sv/quoted_token_splitter.sv */
// Top level of the quoted token splitter: front end, bundle queue, back end.
// Depends on qts_pkg, qts_front, qts_queue and qts_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one item per accepted cycle,
//   either a 16-bit character (i_action = 0) or end of text (i_action = 1).
//   Output channel (o_out_valid / i_out_ready): one result per accepted
//   cycle: token character, token end with its quoted flag, parenthesis
//   token, text done or unterminated-quote error. o_last marks the final
//   result of an item; an unescaped backslash gives no result.
//   The bundle of an accepted item is written into the queue, then loaded
//   into the back end's bundle register, from which its results are sent.
//   The front end takes one item per cycle while the queue is not full;
//   the back end sends one result per ready cycle, so an item with many
//   results holds the output and the output port sets the sustained rate.
//   A two-entry bundle queue sits between the two ends; o_in_ready drops
//   only when it is full, so a stalled receiver backs up into the queue
//   before it stalls the sender.
//   Reset (i_rst_n low, synchronous) clears all token flags and empties the
//   queue; end of text also returns the flags to their reset values.
module quoted_token_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [15:0] i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_char_code_res,
    output logic        o_quoted,
    output logic        o_last
);
    import qts_pkg::*;

    logic    accept, push, pop, q_full;
    t_bundle bundle;
    t_q_stat q_stat;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    qts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .o_push      (push),
        .o_bundle    (bundle)
    );

    qts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_stat   (q_stat)
    );

    qts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stat          (q_stat),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_kind          (o_kind),
        .o_char_code_res (o_char_code_res),
        .o_quoted        (o_quoted),
        .o_last          (o_last)
    );

endmodule

/* tb/qts_tb_pkg.sv */
// Scoreboard for the quoted token splitter testbench: token predictor plus
// the queue of results it expects. Depends on qts_pkg for kinds and widths.
package qts_tb_pkg;
    import qts_pkg::*;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic              quoted;
        logic              last;
    } t_token_out;

    class t_token_checker;
        t_token_out expected_results[$];
        int         mismatch_count;

        // tokenizer flags, mirrored from the block
        bit in_quote_run;
        bit escape_pending;
        bit token_open;
        bit began_with_quote;
        bit token_is_quoted;

        function new();
            mismatch_count = 0;
            clear_flags();
        endfunction

        function void clear_flags();
            in_quote_run     = 1'b0;
            escape_pending   = 1'b0;
            token_open       = 1'b0;
            began_with_quote = 1'b0;
            token_is_quoted  = 1'b0;
        endfunction

        function bit is_blank(logic [CHAR_W-1:0] c);
            return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
                   c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
                   c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
                   c == 16'h3000;
        endfunction

        function void push_result(t_kind k, logic [CHAR_W-1:0] c, logic q);
            expected_results.push_back('{kind: k, ch: c, quoted: q, last: 1'b0});
        endfunction

        // Close the open token, if any; empty tokens leave the quote flags alone.
        function void end_token();
            if (token_open) begin
                push_result(KIND_END, '0, token_is_quoted);
                token_open       = 1'b0;
                token_is_quoted  = 1'b0;
                began_with_quote = 1'b0;
            end
        endfunction

        // Work out the results of one accepted item and queue them.
        function void note_item(logic act, logic [CHAR_W-1:0] c);
            int first;
            first = expected_results.size();
            if (act == ACT_EOT) begin
                if (escape_pending) begin
                    push_result(KIND_CHAR, CH_BACKSLASH, 1'b0);
                    token_open = 1'b1;
                end
                if (in_quote_run) begin
                    push_result(KIND_ERROR, '0, 1'b0);
                end else begin
                    end_token();
                    push_result(KIND_DONE, '0, 1'b0);
                end
                clear_flags();
            end else if (escape_pending) begin
                push_result(KIND_CHAR, c, 1'b0);
                token_open     = 1'b1;
                escape_pending = 1'b0;
            end else if (c == CH_BACKSLASH) begin
                escape_pending = 1'b1;
            end else if (c == CH_QUOTE) begin
                if (!token_open && !in_quote_run) begin
                    began_with_quote = 1'b1;
                end else if (!began_with_quote) begin
                    push_result(KIND_CHAR, c, 1'b0);
                    token_open = 1'b1;
                end
                in_quote_run    = !in_quote_run;
                token_is_quoted = began_with_quote;
            end else if (!in_quote_run && is_blank(c)) begin
                end_token();
            end else if (!in_quote_run && (c == CH_LPAREN || c == CH_RPAREN)) begin
                end_token();
                push_result(KIND_PAREN, c, 1'b0);
            end else begin
                push_result(KIND_CHAR, c, 1'b0);
                token_open = 1'b1;
            end
            if (expected_results.size() > first)
                expected_results[expected_results.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [2:0] kind, logic [CHAR_W-1:0] ch, logic quoted, logic last);
            t_token_out want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d char %h", kind, ch));
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %s", kind, want.kind.name()));
            if (ch !== want.ch)
                report_mismatch($sformatf("char %h, expected %h", ch, want.ch));
            if (quoted !== want.quoted)
                report_mismatch($sformatf("quoted %b, expected %b", quoted, want.quoted));
            if (last !== want.last)
                report_mismatch($sformatf("last %b, expected %b", last, want.last));
        endtask
    endclass

endpackage

/* tb/tb_top.sv */
// Top of the quoted token splitter testbench: clock, reset, item drivers,
// result monitor and watchdog. Depends on qts_pkg, qts_tb_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qts_pkg::*;
    import qts_tb_pkg::*;

    localparam int RANDOM_ITEMS     = 345;
    localparam int QUIET_ITEMS      = 70;
    localparam int HOLD_AFTER_ITEMS = 100;
    localparam int HOLD_CYCLES      = 80;
    localparam int STALL_LIMIT      = 1000;
    localparam int DRAIN_CYCLES     = 10;

    localparam logic [15:0] BLANKS [17] = '{
        16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085, 16'h00A0,
        16'h1680, 16'h2000, 16'h2005, 16'h200A, 16'h2028, 16'h2029, 16'h202F, 16'h205F,
        16'h3000
    };
    // neighbors of the blank and special codes
    localparam logic [15:0] NEAR_MISSES [20] = '{
        16'h0008, 16'h000E, 16'h001F, 16'h0021, 16'h0084, 16'h0086, 16'h009F, 16'h00A1,
        16'h167F, 16'h1681, 16'h1FFF, 16'h200B, 16'h2027, 16'h202A, 16'h202E, 16'h205E,
        16'h2FFF, 16'h3001, 16'h0027, 16'h005B
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [15:0] i_char_code;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_kind;
    logic [15:0] o_char_code_res;
    logic        o_quoted;
    logic        o_last;

    t_token_checker board;
    bit             send_gaps;
    bit             recv_gaps;
    bit             hold_done;
    int             items_accepted;
    int             stall_cycles;

    quoted_token_splitter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_char_code_res (o_char_code_res),
        .o_quoted        (o_quoted),
        .o_last          (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_kind, o_char_code_res, o_quoted, o_last);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL quoted_token_splitter");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one item from a falling edge; return at the falling edge after it is taken.
    task automatic send_item(logic act, logic [15:0] c);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(act, c);
        items_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_char(logic [15:0] c);
        send_item(ACT_CHAR, c);
    endtask

    function automatic logic [15:0] pick_char();
        int          roll;
        logic [15:0] c;
        roll = $urandom_range(0, 99);
        if (roll < 32)      c = 16'h0061 + 16'($urandom_range(0, 25));
        else if (roll < 42) c = CH_QUOTE;
        else if (roll < 49) c = CH_BACKSLASH;
        else if (roll < 53) c = CH_LPAREN;
        else if (roll < 57) c = CH_RPAREN;
        else if (roll < 69) c = BLANKS[$urandom_range(0, 16)];
        else if (roll < 72) c = 16'h2000 + 16'($urandom_range(0, 10));
        else if (roll < 80) c = NEAR_MISSES[$urandom_range(0, 19)];
        else                c = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // Output side: short stalls, plus one long hold that backs up into the input.
    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!hold_done && items_accepted >= HOLD_AFTER_ITEMS) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    end

    initial begin
        int random_sent;
        int text_len;
        board       = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_CHAR;
        i_char_code = '0;
        i_out_ready = 1'b0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;
        random_sent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, quoting, escapes, parentheses, end-of-text cases
        send_char(16'h0000);
        send_char(16'hFFFF);
        send_char(16'h0020);
        send_char(CH_QUOTE);        // opens a quoted token, dropped
        send_char(16'h0061);
        send_char(16'h0020);        // blank inside quotes is kept
        send_char(CH_QUOTE);        // closing quote of a quoted token, dropped
        send_char(CH_LPAREN);       // ends the quoted token, then its own token
        send_char(16'h0062);
        send_char(CH_QUOTE);        // quote inside a token is kept
        send_char(CH_RPAREN);       // parenthesis inside quotes is a plain char
        send_char(CH_QUOTE);
        send_char(CH_BACKSLASH);
        send_char(CH_QUOTE);        // escaped quote
        send_char(16'h3000);
        send_char(CH_QUOTE);        // empty quoted token: flags carry over
        send_char(CH_QUOTE);
        send_char(16'h2029);
        send_char(16'h0063);
        send_item(ACT_EOT, 16'hFFFF);
        send_char(CH_BACKSLASH);    // trailing backslash at end of text
        send_item(ACT_EOT, 16'h0000);
        send_char(CH_QUOTE);        // unterminated quote
        send_char(16'h0078);
        send_item(ACT_EOT, 16'h5555);
        send_item(ACT_EOT, 16'hAAAA);

        // random texts, mostly ended by end of text; the tail runs without idling
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS - QUIET_ITEMS) begin
                send_gaps = ($urandom_range(0, 3) != 0);
                recv_gaps = ($urandom_range(0, 3) != 0);
            end else begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            text_len = $urandom_range(0, 24);
            repeat (text_len) begin
                send_char(pick_char());
                random_sent++;
            end
            if (board.in_quote_run && $urandom_range(0, 3) != 0) begin
                send_char(CH_QUOTE);
                random_sent++;
            end
            if ($urandom_range(0, 7) != 0) begin
                send_item(ACT_EOT, 16'($urandom_range(0, 65535)));
                random_sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0 && board.expected_results.size() == 0) begin
            $display("PASS quoted_token_splitter");
        end else begin
            $display("FAIL quoted_token_splitter");
        end
        $finish;
    end

endmodule
